@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files of the compositor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define AOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define AOC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/aoc_pkg.sv @@
// Types, constants and helper functions of the alpha-over compositor.
`timescale 1ns / 1ps
`default_nettype none

package aoc_pkg;

    localparam int ADDR_W       = 12;
    localparam int PIX_W        = 8;
    localparam int NCH          = 3;
    localparam int PROD_W       = 2 * PIX_W;
    localparam int NUM_W        = 3 * PIX_W;
    localparam int DEN_W        = 2 * PIX_W;
    localparam int REM_W        = NUM_W + 1;
    localparam int DVS_W        = DEN_W + 1;
    localparam int BITS_PER_STG = 2;
    localparam int DIV_STAGES   = PIX_W / BITS_PER_STG;
    localparam int FRONT_STAGES = 3;
    localparam int NSTG         = FRONT_STAGES + DIV_STAGES;

    // floor(x / 255) == (x * 32897) >> 23 for every x below 2^16
    localparam int ALPHA_PROD_W = 32;
    localparam int ALPHA_LSB    = 23;
    localparam logic [ALPHA_PROD_W-1:0] RECIP_255 = ALPHA_PROD_W'(32897);
    localparam logic [ALPHA_PROD_W-1:0] HALF_255  = ALPHA_PROD_W'(127);
    localparam logic [PIX_W-1:0]        PIX_MAX   = {PIX_W{1'b1}};

    typedef enum logic [0:0] {
        MODE_GRAY = 1'b0,
        MODE_RGBA = 1'b1
    } chan_mode_t;

    typedef logic [NCH-1:0][PIX_W-1:0] pix_vec_t;

    // stage 1: alpha weights
    typedef struct packed {
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        pix_vec_t          src;
        pix_vec_t          dst;
        chan_mode_t        mode;
        logic [PROD_W-1:0] s_wt;
        logic [PROD_W-1:0] d_wt;
    } mul_t;

    // stage 2: weighted sums
    typedef struct packed {
        logic [ADDR_W-1:0]          row;
        logic [ADDR_W-1:0]          col;
        pix_vec_t                   dst;
        chan_mode_t                 mode;
        logic [NCH-1:0][NUM_W-1:0]  num;
        logic [DEN_W-1:0]           den;
    } sum_t;

    // stage 3 and the divider stages
    typedef struct packed {
        logic [ADDR_W-1:0]          row;
        logic [ADDR_W-1:0]          col;
        pix_vec_t                   dst;
        chan_mode_t                 mode;
        logic                       den_zero;
        logic [PIX_W-1:0]           alpha;
        logic [NCH-1:0][REM_W-1:0]  rem;
        logic [DVS_W-1:0]           dvs;
        pix_vec_t                   quo;
    } div_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             qbit;
    } div_res_t;

    // One restoring step: try to take divisor << sh out of the remainder.
    function automatic div_res_t div_step(logic [REM_W-1:0] rem, logic [DVS_W-1:0] dvs,
                                          int sh);
        logic [REM_W-1:0] trial;
        div_res_t         res;
        trial = REM_W'(dvs) << sh;
        if (rem >= trial)
        begin
            res.rem  = rem - trial;
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = rem;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/alpha_over_compositor_top.sv @@
// Source-over compositing of straight-alpha pixels, one pixel per clock while out_ready is high.
//
// Channels: the input channel (in_valid/in_ready) carries the write-back address
// plus source and destination pixels; the output channel (out_valid/out_ready)
// returns the address, the blended colour channels and the combined alpha.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes channel_mode: 0 blends
// channel 0 only (gray plus alpha), 1 blends all three colour channels. Write it
// only while no beat is in flight; cfg_ready is always high.
// Throughput: one beat per cycle while out_ready stays high, set by a 7-stage
// pipeline: alpha weights, weighted sums, rounding setup with the alpha reciprocal
// multiply, then a 4-stage restoring divider retiring 2 quotient bits per stage
// for each colour channel.
// Reset: all stages empty, channel_mode returns to RGBA.
// Stall: when out_ready is low the stages fill up behind the waiting beat;
// in_ready drops only once every stage holds a beat. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alpha_over_compositor_top
    import aoc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ADDR_W-1:0]   in_row,
    input  wire logic [ADDR_W-1:0]   in_col,
    input  wire logic [PIX_W-1:0]    src_c0,
    input  wire logic [PIX_W-1:0]    src_c1,
    input  wire logic [PIX_W-1:0]    src_c2,
    input  wire logic [PIX_W-1:0]    src_opacity,
    input  wire logic [PIX_W-1:0]    dst_c0,
    input  wire logic [PIX_W-1:0]    dst_c1,
    input  wire logic [PIX_W-1:0]    dst_c2,
    input  wire logic [PIX_W-1:0]    dst_alpha,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [ADDR_W-1:0]        out_row,
    output logic [ADDR_W-1:0]        out_col,
    output logic [PIX_W-1:0]         out_c0,
    output logic [PIX_W-1:0]         out_c1,
    output logic [PIX_W-1:0]         out_c2,
    output logic [PIX_W-1:0]         out_opacity
);

    chan_mode_t       mode_reg;
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG:0]    en;

    mul_t             mul_reg, mul_next;
    sum_t             sum_reg, sum_next;
    div_t             prep_reg, prep_next;
    div_t             dv_reg  [DIV_STAGES];
    div_t             dv_in   [DIV_STAGES];
    div_t             dv_next [DIV_STAGES];
    div_t             last;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RGBA;
        else if (cfg_valid && cfg_ready)
            mode_reg <= chan_mode_t'(cfg_data);
    end

    // stage enables: a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 1: source weight S*255 and destination weight D*(255-S)
    always_comb
    begin
        mul_next.row  = in_row;
        mul_next.col  = in_col;
        mul_next.src  = {src_c2, src_c1, src_c0};
        mul_next.dst  = {dst_c2, dst_c1, dst_c0};
        mul_next.mode = mode_reg;
        mul_next.s_wt = {src_opacity, {PIX_W{1'b0}}} - PROD_W'(src_opacity);
        mul_next.d_wt = PROD_W'(dst_alpha) * PROD_W'(PIX_MAX - src_opacity);
    end

    // stage 2: per-channel weighted sums and the common denominator
    always_comb
    begin
        sum_next.row  = mul_reg.row;
        sum_next.col  = mul_reg.col;
        sum_next.dst  = mul_reg.dst;
        sum_next.mode = mul_reg.mode;
        sum_next.den  = DEN_W'(mul_reg.s_wt) + DEN_W'(mul_reg.d_wt);
        for (int c = 0; c < NCH; c++)
            sum_next.num[c] = NUM_W'(mul_reg.s_wt) * NUM_W'(mul_reg.src[c])
                            + NUM_W'(mul_reg.d_wt) * NUM_W'(mul_reg.dst[c]);
    end

    // stage 3: round half up as (2*num + den) / (2*den); alpha by reciprocal
    always_comb
    begin
        logic [ALPHA_PROD_W-1:0] aprod;
        aprod = (ALPHA_PROD_W'(sum_reg.den) + HALF_255) * RECIP_255;
        prep_next.row      = sum_reg.row;
        prep_next.col      = sum_reg.col;
        prep_next.dst      = sum_reg.dst;
        prep_next.mode     = sum_reg.mode;
        prep_next.den_zero = (sum_reg.den == '0);
        prep_next.alpha    = aprod[ALPHA_LSB +: PIX_W];
        prep_next.dvs      = {sum_reg.den, 1'b0};
        prep_next.quo      = '0;
        for (int c = 0; c < NCH; c++)
            prep_next.rem[c] = {sum_reg.num[c], 1'b0} + REM_W'(sum_reg.den);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            mul_reg <= mul_next;
        if (en[1])
            sum_reg <= sum_next;
        if (en[2])
            prep_reg <= prep_next;
    end

    // divider: each stage retires the next two quotient bits, MSB first
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int SH_HI = PIX_W - 1 - BITS_PER_STG * j;

        if (j == 0)
        begin : g_first
            assign dv_in[j] = prep_reg;
        end
        else
        begin : g_rest
            assign dv_in[j] = dv_reg[j-1];
        end

        always_comb
        begin
            div_res_t hi;
            div_res_t lo;
            dv_next[j] = dv_in[j];
            for (int c = 0; c < NCH; c++)
            begin
                hi = div_step(dv_in[j].rem[c], dv_in[j].dvs, SH_HI);
                lo = div_step(hi.rem, dv_in[j].dvs, SH_HI - 1);
                dv_next[j].rem[c] = lo.rem;
                dv_next[j].quo[c] = {dv_in[j].quo[c][PIX_W-BITS_PER_STG-1:0],
                                     hi.qbit, lo.qbit};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[FRONT_STAGES + j])
                dv_reg[j] <= dv_next[j];
        end
    end

    // output beat: pass the destination where nothing is blended
    assign last        = dv_reg[DIV_STAGES-1];
    assign out_valid   = vld_reg[NSTG-1];
    assign out_row     = last.row;
    assign out_col     = last.col;
    assign out_opacity = last.alpha;

    always_comb
    begin
        out_c0 = last.den_zero ? last.dst[0] : last.quo[0];
        out_c1 = last.dst[1];
        out_c2 = last.dst[2];
        if (last.mode == MODE_RGBA && !last.den_zero)
        begin
            out_c1 = last.quo[1];
            out_c2 = last.quo[2];
        end
    end

    `AOC_ASSERT(a_accept_fills_first, (in_valid && in_ready) |=> vld_reg[0], "beat lost at entry")
    `AOC_ASSERT(a_stall_only_when_full, !in_ready |-> ((&vld_reg) && !out_ready), "early stall")
    `AOC_ASSERT(a_zero_den_alpha, (out_valid && last.den_zero) |-> out_opacity == '0, "alpha set")
    `AOC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> (vld_reg == '0), "pipeline not empty in reset")

endmodule

`default_nettype wire
